// ===== hdl/tlbpt_pkg.sv =====
`timescale 1ns / 1ps
package tlbpt_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int OFFSET_BITS = 8;
    localparam int FRAME_BITS  = 8;
    localparam int FREE_BITS   = 9;
    localparam int CNT_BITS    = 32;
    localparam int ENTRY_BITS  = FRAME_BITS + 1;

    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int DEF_AGE_BITS    = 16;

    typedef struct packed {
        logic                  upd;
        logic                  is_hit;
        logic [FRAME_BITS-1:0] frame;
    } t_tlb_cmd;

endpackage

// ===== hdl/tlb_page_translator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Ports
// request   in         start && !busy          i_logical_address
// result    out        o_valid, one cycle      o_frame_id .. o_fault_total
//
// TLB hit: busy through the lookup state after the start beat, result strobe in the next cycle.
// TLB miss: busy through a page table read in the lookup state, then a
// victim scan over the TLB ages, one entry per cycle.
// Reset: a clearing pass over all PAGE_COUNT page table entries, busy high.
// The receiver cannot stall; a new start may be taken in the strobe cycle.
module tlb_page_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
    parameter int AGE_BITS    = DEF_AGE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_BITS-1:0]  i_logical_address,
    output logic                  o_valid,
    output logic [FRAME_BITS-1:0] o_frame_id,
    output logic [ADDR_BITS-1:0]  o_physical_address,
    output logic                  o_tlb_hit,
    output logic                  o_page_fault,
    output logic [CNT_BITS-1:0]   o_hit_total,
    output logic [CNT_BITS-1:0]   o_fault_total
);

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int IW = $clog2(TLB_ENTRIES);
    localparam int RW = 20;
    localparam logic [IW-1:0] LAST_IDX = IW'(TLB_ENTRIES - 1);
    localparam logic [PW-1:0] LAST_CLR = PW'(PAGE_COUNT - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN
    } t_state;

    t_state                 r_state;
    logic [PW-1:0]          r_clr_addr;
    logic [PW-1:0]          r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [FRAME_BITS-1:0]  r_frame;
    logic                   r_fault;
    logic [IW-1:0]          r_scan_idx;
    logic [IW-1:0]          r_best_idx;
    logic [AGE_BITS-1:0]    r_best_age;
    logic [FREE_BITS-1:0]   r_next_free;
    logic [CNT_BITS-1:0]    r_hit_count;
    logic [CNT_BITS-1:0]    r_fault_count;
    logic                   r_valid;
    logic [FRAME_BITS-1:0]  r_out_frame;
    logic [ADDR_BITS-1:0]   r_out_paddr;
    logic                   r_out_hit;
    logic                   r_out_fault;

    logic [RW-1:0]          page_red;
    logic [PW-1:0]          page_in;
    logic                   accept;
    logic                   tlb_hit;
    logic [IW-1:0]          tlb_hit_idx;
    logic [FRAME_BITS-1:0]  tlb_hit_frame;
    logic [AGE_BITS-1:0]    scan_age;
    t_tlb_cmd               tlb_cmd;
    logic [IW-1:0]          tlb_idx;
    logic                   mem_we;
    logic [PW-1:0]          mem_waddr;
    logic [ENTRY_BITS-1:0]  mem_wdata;
    logic [ENTRY_BITS-1:0]  mem_rdata;
    logic                   alloc;
    logic [FRAME_BITS-1:0]  miss_frame;
    logic [IW-1:0]          victim;
    logic                   scan_done;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // page modulo PAGE_COUNT by restoring subtraction
    always_comb begin
        page_red = RW'(i_logical_address[ADDR_BITS-1:OFFSET_BITS]);
        for (int k = 3; k >= 0; k--) begin
            if (page_red >= (RW'(PAGE_COUNT) << k)) begin
                page_red = page_red - (RW'(PAGE_COUNT) << k);
            end
        end
        page_in = page_red[PW-1:0];
    end

    assign alloc      = !mem_rdata[FRAME_BITS];
    assign miss_frame = alloc ? r_next_free[FRAME_BITS-1:0] : mem_rdata[FRAME_BITS-1:0];
    assign victim     = (scan_age > r_best_age) ? r_scan_idx : r_best_idx;
    assign scan_done  = (r_scan_idx == LAST_IDX);

    always_comb begin
        tlb_cmd   = '0;
        tlb_idx   = tlb_hit_idx;
        mem_we    = 1'b0;
        mem_waddr = r_page;
        mem_wdata = {1'b1, r_next_free[FRAME_BITS-1:0]};
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_LOOKUP: begin
                if (tlb_hit) begin
                    tlb_cmd.upd    = 1'b1;
                    tlb_cmd.is_hit = 1'b1;
                    tlb_cmd.frame  = tlb_hit_frame;
                end else begin
                    mem_we = alloc;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    tlb_cmd.upd   = 1'b1;
                    tlb_cmd.frame = r_frame;
                    tlb_idx       = victim;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_next_free   <= '0;
            r_hit_count   <= '0;
            r_fault_count <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + PW'(1);
                    if (r_clr_addr == LAST_CLR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_page   <= page_in;
                        r_offset <= i_logical_address[OFFSET_BITS-1:0];
                        r_state  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (tlb_hit) begin
                        r_hit_count <= r_hit_count + CNT_BITS'(1);
                        r_valid     <= 1'b1;
                        r_out_frame <= tlb_hit_frame;
                        r_out_paddr <= {tlb_hit_frame, r_offset};
                        r_out_hit   <= 1'b1;
                        r_out_fault <= 1'b0;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_frame    <= miss_frame;
                        r_fault    <= alloc;
                        r_scan_idx <= '0;
                        r_best_idx <= '0;
                        r_best_age <= '0;
                        if (alloc) begin
                            r_next_free   <= r_next_free + FREE_BITS'(1);
                            r_fault_count <= r_fault_count + CNT_BITS'(1);
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        r_valid     <= 1'b1;
                        r_out_frame <= r_frame;
                        r_out_paddr <= {r_frame, r_offset};
                        r_out_hit   <= 1'b0;
                        r_out_fault <= r_fault;
                        r_state     <= ST_IDLE;
                    end else begin
                        if (scan_age > r_best_age) begin
                            r_best_idx <= r_scan_idx;
                            r_best_age <= scan_age;
                        end
                        r_scan_idx <= r_scan_idx + IW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    tlbpt_page_mem #(
        .DEPTH (PAGE_COUNT),
        .WIDTH (ENTRY_BITS)
    ) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (page_in),
        .o_rdata (mem_rdata)
    );

    tlbpt_tlb_array #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .AGE_BITS    (AGE_BITS)
    ) u_tlb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_page      (r_page),
        .o_hit       (tlb_hit),
        .o_hit_idx   (tlb_hit_idx),
        .o_hit_frame (tlb_hit_frame),
        .i_rd_idx    (r_scan_idx),
        .o_rd_age    (scan_age),
        .i_cmd       (tlb_cmd),
        .i_idx       (tlb_idx)
    );

    assign o_valid            = r_valid;
    assign o_frame_id         = r_out_frame;
    assign o_physical_address = r_out_paddr;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_hit_total        = r_hit_count;
    assign o_fault_total      = r_fault_count;

endmodule

// ===== hdl/tlbpt_page_mem.sv =====
`timescale 1ns / 1ps
module tlbpt_page_mem
    import tlbpt_pkg::*;
#(
    parameter int DEPTH = DEF_PAGE_COUNT,
    parameter int WIDTH = ENTRY_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlbpt_tlb_array.sv =====
`timescale 1ns / 1ps
module tlbpt_tlb_array
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
    parameter int AGE_BITS    = DEF_AGE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(PAGE_COUNT)-1:0]  i_page,
    output logic                           o_hit,
    output logic [$clog2(TLB_ENTRIES)-1:0] o_hit_idx,
    output logic [FRAME_BITS-1:0]          o_hit_frame,
    input  logic [$clog2(TLB_ENTRIES)-1:0] i_rd_idx,
    output logic [AGE_BITS-1:0]            o_rd_age,
    input  t_tlb_cmd                       i_cmd,
    input  logic [$clog2(TLB_ENTRIES)-1:0] i_idx
);

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int IW = $clog2(TLB_ENTRIES);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    logic                  r_valid [TLB_ENTRIES];
    logic [PW-1:0]         r_page  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] r_frame [TLB_ENTRIES];
    logic [AGE_BITS-1:0]   r_age   [TLB_ENTRIES];

    always_comb begin
        o_hit       = 1'b0;
        o_hit_idx   = '0;
        o_hit_frame = '0;
        for (int e = TLB_ENTRIES - 1; e >= 0; e--) begin
            if (r_valid[e] && (r_page[e] == i_page)) begin
                o_hit       = 1'b1;
                o_hit_idx   = IW'(e);
                o_hit_frame = r_frame[e];
            end
        end
    end

    assign o_rd_age = r_age[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < TLB_ENTRIES; e++) begin
                r_valid[e] <= 1'b0;
                r_age[e]   <= '0;
            end
        end else if (i_cmd.upd) begin
            for (int e = 0; e < TLB_ENTRIES; e++) begin
                if (i_idx == IW'(e)) begin
                    r_age[e] <= AGE_ONE;
                    if (!i_cmd.is_hit) begin
                        r_valid[e] <= 1'b1;
                        r_page[e]  <= i_page;
                        r_frame[e] <= i_cmd.frame;
                    end
                end else if (r_age[e] != AGE_MAX) begin
                    r_age[e] <= r_age[e] + AGE_ONE;
                end
            end
        end
    end

endmodule

// ===== hdl/tlbpt_checker.sv =====
`timescale 1ns / 1ps
module tlbpt_checker
    import tlbpt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [FRAME_BITS-1:0] o_frame_id,
    input logic [ADDR_BITS-1:0]  o_physical_address,
    input logic                  o_tlb_hit,
    input logic                  o_page_fault,
    input logic [CNT_BITS-1:0]   o_hit_total,
    input logic [CNT_BITS-1:0]   o_fault_total
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tlb_hit |-> o_hit_total == $past(o_hit_total) + CNT_BITS'(1))
        else $error("hit total not advanced on hit");

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fault_total != $past(o_fault_total)
            |-> o_fault_total == $past(o_fault_total) + CNT_BITS'(1))
        else $error("fault total moved by other than one");

    a_paddr_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_physical_address[ADDR_BITS-1:OFFSET_BITS] == o_frame_id
                    && !(o_tlb_hit && o_page_fault))
        else $error("result beat inconsistent");

endmodule

bind tlb_page_translator tlbpt_checker u_tlbpt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_frame_id         (o_frame_id),
    .o_physical_address (o_physical_address),
    .o_tlb_hit          (o_tlb_hit),
    .o_page_fault       (o_page_fault),
    .o_hit_total        (o_hit_total),
    .o_fault_total      (o_fault_total)
);

// ===== tb/tb_tlb_page_translator.sv =====
`timescale 1ns / 1ps
module tb_tlb_page_translator;
    import tlbpt_pkg::*;

    localparam int TLB_N        = DEF_TLB_ENTRIES;
    localparam int PAGE_N       = DEF_PAGE_COUNT;
    localparam int PAGE_BITS    = ADDR_BITS - OFFSET_BITS;
    localparam int DIRECTED_N   = 25;
    localparam int PHASE_N      = 6;
    localparam int PHASE_ITEMS  = 271;
    localparam int DRAIN_CYCLES = TLB_N + 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [ADDR_BITS-1:0]  phys;
        logic                  hit;
        logic                  fault;
        logic [CNT_BITS-1:0]   hits;
        logic [CNT_BITS-1:0]   faults;
    } t_translation;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 typed;
        t_translation         result;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ADDR_BITS-1:0]  i_logical_address = '0;
    logic                  o_valid;
    logic [FRAME_BITS-1:0] o_frame_id;
    logic [ADDR_BITS-1:0]  o_physical_address;
    logic                  o_tlb_hit;
    logic                  o_page_fault;
    logic [CNT_BITS-1:0]   o_hit_total;
    logic [CNT_BITS-1:0]   o_fault_total;

    // translation model state
    logic                    tlb_valid_m [TLB_N];
    logic [PAGE_BITS-1:0]    tlb_page_m  [TLB_N];
    logic [FRAME_BITS-1:0]   tlb_frame_m [TLB_N];
    logic [DEF_AGE_BITS-1:0] tlb_age_m   [TLB_N];
    logic                    table_valid_m [PAGE_N];
    logic [FRAME_BITS-1:0]   table_frame_m [PAGE_N];
    logic [FREE_BITS-1:0]    next_frame_m;
    logic [CNT_BITS-1:0]     hit_count_m;
    logic [CNT_BITS-1:0]     fault_count_m;

    t_translation pending_translations[$];
    t_translation wanted;
    int           error_count = 0;
    int           cycle_count = 0;
    int           beat_count = 0;
    int           seen_hits = 0;
    int           seen_faults = 0;
    bit           steady = 1'b0;

    t_directed_row directed_rows [DIRECTED_N] = '{
        '{16'h0000, 1'b1, '{8'h00, 16'h0000, 1'b0, 1'b1, 32'd0, 32'd1}},
        '{16'hFFFF, 1'b1, '{8'h01, 16'h01FF, 1'b0, 1'b1, 32'd0, 32'd2}},
        '{16'h00AB, 1'b1, '{8'h00, 16'h00AB, 1'b0, 1'b0, 32'd0, 32'd2}},
        '{16'hFF00, 1'b1, '{8'h01, 16'h0100, 1'b1, 1'b0, 32'd1, 32'd2}},
        '{16'h0000, 1'b0, '0},
        '{16'h1000, 1'b0, '0},
        '{16'h1101, 1'b0, '0},
        '{16'h12FE, 1'b0, '0},
        '{16'h1380, 1'b0, '0},
        '{16'h147F, 1'b0, '0},
        '{16'h15FF, 1'b0, '0},
        '{16'h1601, 1'b0, '0},
        '{16'h1755, 1'b0, '0},
        '{16'h18AA, 1'b0, '0},
        '{16'h1900, 1'b0, '0},
        '{16'h1A0F, 1'b0, '0},
        '{16'h1BF0, 1'b0, '0},
        '{16'h1C33, 1'b0, '0},
        '{16'h1DCC, 1'b0, '0},
        '{16'h1E5A, 1'b0, '0},
        '{16'h1FA5, 1'b0, '0},
        '{16'h0042, 1'b0, '0},
        '{16'hFF80, 1'b0, '0},
        '{16'h1F00, 1'b0, '0},
        '{16'h8000, 1'b0, '0}
    };

    int phase_ws_size [PHASE_N] = '{3, 16, 17, 8, 30, 15};

    tlb_page_translator DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_logical_address  (i_logical_address),
        .o_valid            (o_valid),
        .o_frame_id         (o_frame_id),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic clear_translation_state();
        for (int i = 0; i < TLB_N; i++) begin
            tlb_valid_m[i] = 1'b0;
            tlb_page_m[i]  = '0;
            tlb_frame_m[i] = '0;
            tlb_age_m[i]   = '0;
        end
        for (int p = 0; p < PAGE_N; p++) begin
            table_valid_m[p] = 1'b0;
            table_frame_m[p] = '0;
        end
        next_frame_m  = '0;
        hit_count_m   = '0;
        fault_count_m = '0;
    endtask

    task automatic translate_address(input logic [ADDR_BITS-1:0] addr,
                                     output t_translation res);
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic                  hit;
        logic                  fault;
        int                    found;
        int                    victim;
        page  = PAGE_BITS'(addr[ADDR_BITS-1:OFFSET_BITS] % PAGE_N);
        hit   = 1'b0;
        fault = 1'b0;
        found = -1;
        for (int i = 0; i < TLB_N; i++) begin
            if (found < 0 && tlb_valid_m[i] && tlb_page_m[i] == page) begin
                found = i;
            end
        end
        if (found >= 0) begin
            hit = 1'b1;
            hit_count_m++;
            tlb_age_m[found] = '0;
            frame = tlb_frame_m[found];
        end else begin
            if (!table_valid_m[page]) begin
                fault = 1'b1;
                fault_count_m++;
                table_frame_m[page] = next_frame_m[FRAME_BITS-1:0];
                table_valid_m[page] = 1'b1;
                next_frame_m++;
            end
            frame  = table_frame_m[page];
            victim = 0;
            for (int i = 1; i < TLB_N; i++) begin
                if (tlb_age_m[i] > tlb_age_m[victim]) begin
                    victim = i;
                end
            end
            tlb_valid_m[victim] = 1'b1;
            tlb_page_m[victim]  = page;
            tlb_frame_m[victim] = frame;
            tlb_age_m[victim]   = '0;
        end
        for (int i = 0; i < TLB_N; i++) begin
            if (tlb_age_m[i] != '1) begin
                tlb_age_m[i]++;
            end
        end
        res = '{frame, {frame, addr[OFFSET_BITS-1:0]}, hit, fault,
                hit_count_m, fault_count_m};
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 4);
        end else if (r < 95) begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(21, 60);
    endfunction

    // returns at the edge where the beat is taken; start stays high
    task automatic send_beat(input logic [ADDR_BITS-1:0] addr, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_logical_address <= addr;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        beat_count++;
    endtask

    task automatic check_field(input string name, input logic [CNT_BITS-1:0] want,
                               input logic [CNT_BITS-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_translations.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual frame %0h addr %0h",
                         $time, o_frame_id, o_physical_address);
            end else begin
                wanted = pending_translations.pop_front();
                check_field("frame_id", CNT_BITS'(wanted.frame), CNT_BITS'(o_frame_id));
                check_field("physical_address", CNT_BITS'(wanted.phys),
                            CNT_BITS'(o_physical_address));
                check_field("tlb_hit", CNT_BITS'(wanted.hit), CNT_BITS'(o_tlb_hit));
                check_field("page_fault", CNT_BITS'(wanted.fault), CNT_BITS'(o_page_fault));
                check_field("hit_total", wanted.hits, o_hit_total);
                check_field("fault_total", wanted.faults, o_fault_total);
                seen_hits   += o_tlb_hit;
                seen_faults += o_page_fault;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_translations.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_translation         predicted;
        logic [ADDR_BITS-1:0] addr;
        logic [PAGE_BITS-1:0] ws_base;
        int                   ws_size;
        clear_translation_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].addr, pick_gap());
            translate_address(directed_rows[k].addr, predicted);
            if (directed_rows[k].typed) begin
                pending_translations.push_back(directed_rows[k].result);
            end else begin
                pending_translations.push_back(predicted);
            end
        end

        for (int ph = 0; ph < PHASE_N; ph++) begin
            start <= 1'b0;
            while (pending_translations.size() != 0) @(posedge i_clk);
            steady  = (ph % 3 == 1);
            ws_size = phase_ws_size[ph];
            ws_base = PAGE_BITS'($urandom_range(PAGE_N - 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 75) begin
                    addr = {ws_base + PAGE_BITS'($urandom_range(ws_size - 1)),
                            OFFSET_BITS'($urandom_range(255))};
                end else begin
                    addr = ADDR_BITS'($urandom_range(16'hFFFF));
                end
                send_beat(addr, pick_gap());
                translate_address(addr, predicted);
                pending_translations.push_back(predicted);
            end
        end

        start <= 1'b0;
        while (pending_translations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_translations.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_translations.size());
        end
        $display("tb: %0d addresses translated over %0d working-set phases,", beat_count,
                 PHASE_N);
        $display("tb: %0d TLB hits and %0d page faults seen, %0d errors", seen_hits,
                 seen_faults, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tlbpt_pkg.sv
hdl/tlbpt_page_mem.sv
hdl/tlbpt_tlb_array.sv
hdl/tlb_page_translator.sv
hdl/tlbpt_checker.sv
tb/tb_tlb_page_translator.sv
